// ===== src/blr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the bilinear resize block.
// No dependencies; blr_ctrl, blr_dp and the top level import this package.
package blr_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int DEF_MAX_SOURCE_SIDE = 256;
  localparam int DEF_MAX_TARGET_SIDE = 1024;
  localparam int DEF_FRACTION_BITS   = 16;

  // Fixed field widths of the ports
  localparam int CH_W       = 8;
  localparam int CHANNELS   = 3;
  localparam int PIX_W      = CH_W * CHANNELS;
  localparam int COORD_W    = 10;
  localparam int SRC_REG_W  = 9;
  localparam int TGT_REG_W  = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 2'd3;

  // Operation and status codes
  localparam logic OP_LOAD      = 1'b0;
  localparam logic OP_SAMPLE    = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef struct packed {
    logic               op;
    logic [CH_W-1:0]    in_red;
    logic [CH_W-1:0]    in_green;
    logic [CH_W-1:0]    in_blue;
    logic [COORD_W-1:0] dst_col;
    logic [COORD_W-1:0] dst_row;
  } in_t;

  typedef struct packed {
    logic [CH_W-1:0]    res_red;
    logic [CH_W-1:0]    res_green;
    logic [CH_W-1:0]    res_blue;
    logic [COORD_W-1:0] res_col;
    logic [COORD_W-1:0] res_row;
    logic               status;
  } out_t;

  // Neighbour select: left/right column, top/bottom row
  typedef enum logic [1:0] {
    NBR_00,
    NBR_10,
    NBR_01,
    NBR_11
  } nbr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_WAIT_X,
    ST_DIV_Y,
    ST_WAIT_Y,
    ST_MAP,
    ST_IDX,
    ST_BASE,
    ST_RD00,
    ST_RD10,
    ST_RD01,
    ST_RD11,
    ST_LAST,
    ST_HORIZ,
    ST_VERT,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic load_wr;
    logic div_start;
    logic ratio_ld;
    logic axis_y;
    logic map;
    logic idx;
    logic base;
    nbr_t rd_sel;
    logic lat_en;
    nbr_t lat_sel;
    logic horiz;
    logic vert;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic oob;
  } sts_t;

endpackage

// ===== src/blr_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module blr_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q;
  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Shift the next numerator bit into the partial remainder and try the subtract
  always_comb begin
    trial = {rem, q[NUM_W-1]};
    diff  = trial - {1'b0, den};
    ge    = (trial >= {1'b0, den});
  end

  // Step count and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(NUM_W);
      end else if (run) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Numerator shifts out at the top while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
    end else if (run) begin
      q   <= {q[NUM_W-2:0], ge};
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign quot = q;

endmodule

// ===== src/blr_ctrl.sv =====
`timescale 1ns / 1ps
// Controller for the bilinear resize block: sequences ratio division,
// coordinate mapping, frame store reads and interpolation. Uses blr_pkg.
module blr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          op,
  input  logic          cfg_we,
  input  blr_pkg::sts_t sts,
  output blr_pkg::cmd_t cmd,
  output logic          busy
);
  import blr_pkg::*;

  state_t state, state_next;
  logic   stale;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Mark ratios out of date on any register write; a write wins over the clear
  always_ff @(posedge clk) begin
    if (rst) begin
      stale <= 1'b0;
    end else if (cfg_we) begin
      stale <= 1'b1;
    end else if (state == ST_IDLE) begin
      stale <= 1'b0;
    end
  end

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    busy       = (state != ST_IDLE) || stale;
    case (state)
      ST_IDLE: begin
        if (stale) begin
          state_next = ST_DIV_X;
        end else if (start) begin
          cmd.accept = 1'b1;
          if (op == OP_LOAD) begin
            cmd.load_wr = 1'b1;
          end else begin
            state_next = ST_MAP;
          end
        end
      end
      ST_DIV_X: begin
        cmd.div_start = 1'b1;
        state_next    = ST_WAIT_X;
      end
      ST_WAIT_X: begin
        if (sts.div_done) begin
          cmd.ratio_ld = 1'b1;
          state_next   = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        cmd.div_start = 1'b1;
        cmd.axis_y    = 1'b1;
        state_next    = ST_WAIT_Y;
      end
      ST_WAIT_Y: begin
        cmd.axis_y = 1'b1;
        if (sts.div_done) begin
          cmd.ratio_ld = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_MAP: begin
        if (sts.oob) begin
          state_next = ST_EMIT;
        end else begin
          cmd.map    = 1'b1;
          state_next = ST_IDX;
        end
      end
      ST_IDX: begin
        cmd.idx    = 1'b1;
        state_next = ST_BASE;
      end
      ST_BASE: begin
        cmd.base   = 1'b1;
        state_next = ST_RD00;
      end
      ST_RD00: begin
        cmd.rd_sel = NBR_00;
        state_next = ST_RD10;
      end
      ST_RD10: begin
        cmd.rd_sel  = NBR_10;
        cmd.lat_en  = 1'b1;
        cmd.lat_sel = NBR_00;
        state_next  = ST_RD01;
      end
      ST_RD01: begin
        cmd.rd_sel  = NBR_01;
        cmd.lat_en  = 1'b1;
        cmd.lat_sel = NBR_10;
        state_next  = ST_RD11;
      end
      ST_RD11: begin
        cmd.rd_sel  = NBR_11;
        cmd.lat_en  = 1'b1;
        cmd.lat_sel = NBR_01;
        state_next  = ST_LAST;
      end
      ST_LAST: begin
        cmd.lat_en  = 1'b1;
        cmd.lat_sel = NBR_11;
        state_next  = ST_HORIZ;
      end
      ST_HORIZ: begin
        cmd.horiz  = 1'b1;
        state_next = ST_VERT;
      end
      ST_VERT: begin
        cmd.vert   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/blr_dp.sv =====
`timescale 1ns / 1ps
// Datapath for the bilinear resize block: size registers, ratio divider,
// frame store, coordinate mapping and interpolation lanes. Uses blr_pkg, blr_div.
module blr_dp #(
  parameter int MAX_SOURCE_SIDE = blr_pkg::DEF_MAX_SOURCE_SIDE,
  parameter int MAX_TARGET_SIDE = blr_pkg::DEF_MAX_TARGET_SIDE,
  parameter int FRACTION_BITS   = blr_pkg::DEF_FRACTION_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [blr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [blr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  blr_pkg::in_t                   item,
  input  blr_pkg::cmd_t                  cmd,
  output blr_pkg::sts_t                  sts,
  output logic                           done,
  output blr_pkg::out_t                  result
);
  import blr_pkg::*;

  localparam int SIW    = $clog2(MAX_SOURCE_SIDE);
  localparam int SSW    = $clog2(MAX_SOURCE_SIDE + 1);
  localparam int TIW    = $clog2(MAX_TARGET_SIDE);
  localparam int TSW    = $clog2(MAX_TARGET_SIDE + 1);
  localparam int RW     = SIW + FRACTION_BITS;
  localparam int PW     = COORD_W + RW;
  localparam int IPW    = PW - FRACTION_BITS;
  localparam int DEPTH  = MAX_SOURCE_SIDE * MAX_SOURCE_SIDE;
  localparam int AW     = $clog2(DEPTH);
  localparam int AREA_W = $clog2(DEPTH + 1);
  localparam int FW     = FRACTION_BITS + 1;
  localparam int HW     = CH_W + FRACTION_BITS;
  localparam int VW     = CH_W + 2 * FRACTION_BITS;
  localparam logic [FW-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  // Configuration registers
  logic [SRC_REG_W-1:0] source_width, source_height;
  logic [TGT_REG_W-1:0] target_width, target_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SRC_REG_W'(1);
      source_height <= SRC_REG_W'(1);
      target_width  <= TGT_REG_W'(1);
      target_height <= TGT_REG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:  source_width  <= cfg_data[SRC_REG_W-1:0];
        REG_SOURCE_HEIGHT: source_height <= cfg_data[SRC_REG_W-1:0];
        REG_TARGET_WIDTH:  target_width  <= cfg_data[TGT_REG_W-1:0];
        REG_TARGET_HEIGHT: target_height <= cfg_data[TGT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp sizes to one .. maximum side
  logic [SSW-1:0] sw_eff, sh_eff;
  logic [TSW-1:0] tw_eff, th_eff;
  logic [SIW-1:0] sw_m1, sh_m1;
  logic [TIW-1:0] tw_m1, th_m1;

  always_comb begin
    sw_eff = (source_width == '0) ? SSW'(1) :
             (32'(source_width) > 32'(MAX_SOURCE_SIDE)) ? SSW'(MAX_SOURCE_SIDE) :
             SSW'(source_width);
    sh_eff = (source_height == '0) ? SSW'(1) :
             (32'(source_height) > 32'(MAX_SOURCE_SIDE)) ? SSW'(MAX_SOURCE_SIDE) :
             SSW'(source_height);
    tw_eff = (target_width == '0) ? TSW'(1) :
             (32'(target_width) > 32'(MAX_TARGET_SIDE)) ? TSW'(MAX_TARGET_SIDE) :
             TSW'(target_width);
    th_eff = (target_height == '0) ? TSW'(1) :
             (32'(target_height) > 32'(MAX_TARGET_SIDE)) ? TSW'(MAX_TARGET_SIDE) :
             TSW'(target_height);
    sw_m1  = SIW'(sw_eff - SSW'(1));
    sh_m1  = SIW'(sh_eff - SSW'(1));
    tw_m1  = TIW'(tw_eff - TSW'(1));
    th_m1  = TIW'(th_eff - TSW'(1));
  end

  // Frame area, refreshed every cycle
  logic [AREA_W-1:0] area;

  always_ff @(posedge clk) begin
    if (rst) begin
      area <= AREA_W'(1);
    end else begin
      area <= AREA_W'(AREA_W'(sw_eff) * AREA_W'(sh_eff));
    end
  end

  // Ratio divider, shared by both axes
  logic [RW-1:0]  div_num;
  logic [TIW-1:0] div_den;
  logic [RW-1:0]  div_quot;
  logic           div_done;
  logic           unit_side;
  logic [RW-1:0]  ratio_x, ratio_y;

  always_comb begin
    div_num   = cmd.axis_y ? {sh_m1, {FRACTION_BITS{1'b0}}}
                           : {sw_m1, {FRACTION_BITS{1'b0}}};
    div_den   = cmd.axis_y ? th_m1 : tw_m1;
    unit_side = cmd.axis_y ? (th_eff == TSW'(1)) : (tw_eff == TSW'(1));
  end

  blr_div #(
    .NUM_W(RW),
    .DEN_W(TIW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot)
  );

  // Hold ratios; a target side of one maps everything to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_x <= '0;
      ratio_y <= '0;
    end else if (cmd.ratio_ld) begin
      if (cmd.axis_y) begin
        ratio_y <= unit_side ? '0 : div_quot;
      end else begin
        ratio_x <= unit_side ? '0 : div_quot;
      end
    end
  end

  // Capture the requested coordinate
  logic [COORD_W-1:0] req_col, req_row;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_col <= item.dst_col;
      req_row <= item.dst_row;
    end
  end

  assign sts.div_done = div_done;
  assign sts.oob      = (32'(req_col) >= 32'(tw_eff)) || (32'(req_row) >= 32'(th_eff));

  // Write position, wrapping at the frame area
  logic [AW-1:0]     wp, wr_addr, wp_next;
  logic [AREA_W-1:0] wr_inc;

  always_comb begin
    wr_addr = (AREA_W'(wp) >= area) ? '0 : wp;
    wr_inc  = AREA_W'(wr_addr) + AREA_W'(1);
    wp_next = (wr_inc >= area) ? '0 : AW'(wr_inc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
    end else if (cmd.load_wr) begin
      wp <= wp_next;
    end
  end

  // Source position along each axis
  logic [PW-1:0] px, py;

  always_ff @(posedge clk) begin
    if (cmd.map) begin
      px <= PW'(req_col) * PW'(ratio_x);
      py <= PW'(req_row) * PW'(ratio_y);
    end
  end

  // Neighbour indices and fractions, clamped at the last column and row
  logic [IPW-1:0] ipx, ipy;
  logic           x_clip, y_clip;
  logic [SIW-1:0] x0_c, x1_c, y0_c, y1_c;
  logic [FW-1:0]  fx_c, fy_c;
  logic [SIW-1:0] x0, x1, y0, y1;
  logic [FW-1:0]  fx, fy;

  always_comb begin
    ipx    = px[PW-1:FRACTION_BITS];
    ipy    = py[PW-1:FRACTION_BITS];
    x_clip = ipx > IPW'(sw_m1);
    y_clip = ipy > IPW'(sh_m1);
    x0_c   = x_clip ? sw_m1 : ipx[SIW-1:0];
    y0_c   = y_clip ? sh_m1 : ipy[SIW-1:0];
    fx_c   = x_clip ? ONE : {1'b0, px[FRACTION_BITS-1:0]};
    fy_c   = y_clip ? ONE : {1'b0, py[FRACTION_BITS-1:0]};
    x1_c   = (x0_c < sw_m1) ? SIW'(x0_c + SIW'(1)) : sw_m1;
    y1_c   = (y0_c < sh_m1) ? SIW'(y0_c + SIW'(1)) : sh_m1;
  end

  always_ff @(posedge clk) begin
    if (cmd.idx) begin
      x0 <= x0_c;
      x1 <= x1_c;
      y0 <= y0_c;
      y1 <= y1_c;
      fx <= fx_c;
      fy <= fy_c;
    end
  end

  // Row base addresses
  logic [AW-1:0] base0, base1;

  always_ff @(posedge clk) begin
    if (cmd.base) begin
      base0 <= AW'(AW'(y0) * AW'(sw_eff));
      base1 <= AW'(AW'(y1) * AW'(sw_eff));
    end
  end

  // Select the neighbour address to read
  logic [AW-1:0] rd_addr;

  always_comb begin
    case (cmd.rd_sel)
      NBR_00:  rd_addr = base0 + AW'(x0);
      NBR_10:  rd_addr = base0 + AW'(x1);
      NBR_01:  rd_addr = base1 + AW'(x0);
      NBR_11:  rd_addr = base1 + AW'(x1);
      default: rd_addr = base0 + AW'(x0);
    endcase
  end

  // Frame store, one write and one registered read port
  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      mem[wr_addr] <= {item.in_blue, item.in_green, item.in_red};
    end
    rd_data <= mem[rd_addr];
  end

  // Hold the four neighbours as they come back
  logic [PIX_W-1:0] p00, p10, p01, p11;

  always_ff @(posedge clk) begin
    if (cmd.lat_en) begin
      case (cmd.lat_sel)
        NBR_00:  p00 <= rd_data;
        NBR_10:  p10 <= rd_data;
        NBR_01:  p01 <= rd_data;
        NBR_11:  p11 <= rd_data;
        default: p00 <= rd_data;
      endcase
    end
  end

  // One lane per channel: horizontal blend, then vertical blend
  logic [CH_W-1:0] vbyte [CHANNELS];

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    logic [HW-1:0] top, bot;
    logic [VW-1:0] v;

    always_ff @(posedge clk) begin
      if (cmd.horiz) begin
        top <= HW'(HW'(p00[c*CH_W +: CH_W]) * HW'(ONE - fx))
             + HW'(HW'(p10[c*CH_W +: CH_W]) * HW'(fx));
        bot <= HW'(HW'(p01[c*CH_W +: CH_W]) * HW'(ONE - fx))
             + HW'(HW'(p11[c*CH_W +: CH_W]) * HW'(fx));
      end
    end

    assign v = VW'(top) * VW'(ONE - fy) + VW'(bot) * VW'(fy);

    always_ff @(posedge clk) begin
      if (cmd.vert) begin
        vbyte[c] <= v[VW-1 -: CH_W];
      end
    end
  end

  // Result register and strobe
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.res_red   <= sts.oob ? '0 : vbyte[0];
      result.res_green <= sts.oob ? '0 : vbyte[1];
      result.res_blue  <= sts.oob ? '0 : vbyte[2];
      result.res_col   <= req_col;
      result.res_row   <= req_row;
      result.status    <= sts.oob ? STATUS_RANGE : STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

endmodule

// ===== src/bilinear_resize_align_corners_rgb8.sv =====
`timescale 1ns / 1ps
// Top level of the bilinear resize block (align-corners, RGB 8 bits).
// Depends on blr_pkg, blr_ctrl, blr_dp (and blr_div below it).
//
//   channel   ports                          transaction
//   command   start, busy, item              start high while busy low
//   result    done, result                   done high for one cycle
//   config    cfg_we, cfg_index, cfg_data    cfg_we high at a clock edge
//
// A load is written as it is accepted and the block is ready again at once. A
// sample keeps busy high through the coordinate multiply, index and row-base
// steps, four reads through the single frame store read port and two blend
// steps, and done is registered from the final emit step; an out-of-range
// coordinate goes straight from the mapping check to the emit step. After a
// register write busy stays high while the shared divider recomputes both
// ratios, one quotient bit a cycle. Reset clears the control state and sets
// all sizes to one; the frame store is not cleared. The receiver cannot stall,
// so results leave on the cycle they are ready.
module bilinear_resize_align_corners_rgb8 #(
  parameter int MAX_SOURCE_SIDE = blr_pkg::DEF_MAX_SOURCE_SIDE,
  parameter int MAX_TARGET_SIDE = blr_pkg::DEF_MAX_TARGET_SIDE,
  parameter int FRACTION_BITS   = blr_pkg::DEF_FRACTION_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  blr_pkg::in_t                   item,
  output logic                           busy,
  output logic                           done,
  output blr_pkg::out_t                  result,
  input  logic                           cfg_we,
  input  logic [blr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [blr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import blr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence control
  blr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (item.op),
    .cfg_we(cfg_we),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Storage and arithmetic
  blr_dp #(
    .MAX_SOURCE_SIDE(MAX_SOURCE_SIDE),
    .MAX_TARGET_SIDE(MAX_TARGET_SIDE),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .item     (item),
    .cmd      (cmd),
    .sts      (sts),
    .done     (done),
    .result   (result)
  );

endmodule
